// ===== rtl/core/adc_ladder_button_decoder_core_macros.svh =====
// Assertion helpers shared by the decoder core.
`ifndef ADC_LADDER_BUTTON_DECODER_CORE_MACROS_SVH
`define ADC_LADDER_BUTTON_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ALBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("albd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ALBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("albd assertion failed");

`endif

// ===== rtl/core/albd_pkg.sv =====
`default_nettype none

package albd_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned SET_W    = 4;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CODES_MAX = 2 ** SET_W;

  localparam int unsigned LADDER_CODES_DEF = 16;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] STABLE_DELTA_RST       = 12'd10;
  localparam logic [TIME_W-1:0]   STABLE_TIME_NEEDED_RST = 16'd200;
  localparam logic [SAMPLE_W-1:0] RELEASE_LEVEL_RST      = 12'h800;
  localparam logic [TIME_W-1:0]   REBOOT_HOLD_TIME_RST   = 16'd3000;

  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  // Button sets with a meaning of their own
  localparam logic [SET_W-1:0] SET_NONE = 4'd0;
  localparam logic [SET_W-1:0] SET_ALL4 = 4'd15;

  // Ladder voltage codes; entry 0 is the open line and never matches
  localparam logic [SAMPLE_W-1:0] LADDER_CODE [CODES_MAX] = '{
    12'hFFF, 12'h0C0, 12'h196, 12'h086, 12'h308, 12'h0A0, 12'h11E, 12'h076,
    12'h55D, 12'h0B1, 12'h154, 12'h080, 12'h235, 12'h095, 12'h0FA, 12'h070
  };

  typedef enum logic [1:0] {
    CFG_STABLE_DELTA       = 2'd0,
    CFG_STABLE_TIME_NEEDED = 2'd1,
    CFG_RELEASE_LEVEL      = 2'd2,
    CFG_REBOOT_HOLD_TIME   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   elapsed;
    logic                menu_active;
  } in_t;

  typedef struct packed {
    logic [SET_W-1:0]  buttons;
    logic [SET_W-1:0]  previous_buttons;
    logic              notify_host;
    logic              notify_menu;
    logic [TIME_W-1:0] hold_time;
    logic              start_menu;
    logic              released;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/albd_nearest.sv =====
`default_nettype none

module albd_nearest #(
  parameter int unsigned LADDER_CODES = albd_pkg::LADDER_CODES_DEF
) (
  input  logic [albd_pkg::SAMPLE_W-1:0] sample,
  output logic [albd_pkg::SET_W-1:0]    nearest
);

  typedef struct packed {
    logic [albd_pkg::SET_W-1:0] idx;
    logic [albd_pkg::SAMPLE_W:0] err;
  } cand_t;

  cand_t lvl0 [albd_pkg::CODES_MAX];
  cand_t lvl1 [albd_pkg::CODES_MAX/2];
  cand_t lvl2 [albd_pkg::CODES_MAX/4];
  cand_t lvl3 [albd_pkg::CODES_MAX/8];
  cand_t best;

  // Keep the left candidate on a tie so the lowest index wins
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.err < a.err) ? b : a;
  endfunction

  // Distance to every ladder code; unused slots get an unbeatable distance
  always_comb begin
    for (int i = 0; i < albd_pkg::CODES_MAX; i++) begin
      lvl0[i].idx = albd_pkg::SET_W'(i);
      if (i == 0 || i >= LADDER_CODES) begin
        lvl0[i].err = '1;
      end else if (sample > albd_pkg::LADDER_CODE[i]) begin
        lvl0[i].err = {1'b0, sample - albd_pkg::LADDER_CODE[i]};
      end else begin
        lvl0[i].err = {1'b0, albd_pkg::LADDER_CODE[i] - sample};
      end
    end
  end

  // Minimum tree, four levels
  always_comb begin
    for (int i = 0; i < albd_pkg::CODES_MAX/2; i++) lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
    for (int i = 0; i < albd_pkg::CODES_MAX/4; i++) lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    for (int i = 0; i < albd_pkg::CODES_MAX/8; i++) lvl3[i] = pick(lvl2[2*i], lvl2[2*i+1]);
    best = pick(lvl3[0], lvl3[1]);
  end

  assign nearest = best.idx;

endmodule

`default_nettype wire

// ===== rtl/core/adc_ladder_button_decoder_core.sv =====
// Channel | Ports                          | Direction | Moves
// in      | in_valid, in_ready, in_data    | input     | one ADC sample request
// out     | out_valid, out_ready, out_data | output    | one decoded result
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input | one register write
//
// Two register stages: an input stage that also holds the nearest ladder code,
// then the result register that updates the decoder state.
// One request per cycle sustained unless the output stalls; out_valid rises
// as a request moves from the input stage into the result register.
// The loop through the stable/hold timers and set registers sets the rate.
// Reset (rst_n low, synchronous) clears state and loads register defaults.
// A stalled output holds both stages; cfg_ready is always high.
`default_nettype none

module adc_ladder_button_decoder_core #(
  parameter int unsigned LADDER_CODES = albd_pkg::LADDER_CODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  albd_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output albd_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [albd_pkg::CFG_W-1:0] cfg_data
);

`include "adc_ladder_button_decoder_core_macros.svh"

  localparam int unsigned SW = albd_pkg::SAMPLE_W;
  localparam int unsigned TW = albd_pkg::TIME_W;
  localparam int unsigned BW = albd_pkg::SET_W;

  // Configuration registers
  logic [SW-1:0] stable_delta_r;
  logic [TW-1:0] stable_time_needed_r;
  logic [SW-1:0] release_level_r;
  logic [TW-1:0] reboot_hold_time_r;

  // Decoder state
  logic [SW-1:0] last_sample_r, last_sample_nxt;
  logic [TW-1:0] stable_time_r, stable_time_nxt;
  logic [BW-1:0] current_set_r, current_set_nxt;
  logic [BW-1:0] prior_set_r, prior_set_nxt;
  logic [TW-1:0] held_time_r, held_time_nxt;

  // Input stage
  logic          s1_valid_r;
  albd_pkg::in_t s1_data_r;
  logic [BW-1:0] s1_nearest_r;
  logic [BW-1:0] nearest_c;

  // Result stage
  logic           out_valid_r;
  albd_pkg::out_t out_data_r, out_data_nxt;

  logic s1_move, out_free;

  // Stage 1 combinational: pick nearest ladder code for the incoming sample
  albd_nearest #(
    .LADDER_CODES(LADDER_CODES)
  ) u_nearest (
    .sample  (in_data.sample),
    .nearest (nearest_c)
  );

  // Handshake
  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || s1_move;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_delta_r       <= albd_pkg::STABLE_DELTA_RST;
      stable_time_needed_r <= albd_pkg::STABLE_TIME_NEEDED_RST;
      release_level_r      <= albd_pkg::RELEASE_LEVEL_RST;
      reboot_hold_time_r   <= albd_pkg::REBOOT_HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (albd_pkg::cfg_reg_t'(cfg_index))
        albd_pkg::CFG_STABLE_DELTA:       stable_delta_r       <= cfg_data[SW-1:0];
        albd_pkg::CFG_STABLE_TIME_NEEDED: stable_time_needed_r <= cfg_data[TW-1:0];
        albd_pkg::CFG_RELEASE_LEVEL:      release_level_r      <= cfg_data[SW-1:0];
        albd_pkg::CFG_REBOOT_HOLD_TIME:   reboot_hold_time_r   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 2: stability timer, decode, hold timer
  logic [SW-1:0] diff;
  logic [TW:0]   st_sum, hold_sum;
  logic [TW-1:0] hold_base;
  logic          decode, released_c;
  logic [BW-1:0] set_c;

  always_comb begin
    diff = (s1_data_r.sample > last_sample_r) ? (s1_data_r.sample - last_sample_r)
                                              : (last_sample_r - s1_data_r.sample);
    st_sum = {1'b0, stable_time_r} + {1'b0, s1_data_r.elapsed};

    last_sample_nxt = s1_data_r.sample;
    if (diff < stable_delta_r) begin
      stable_time_nxt = st_sum[TW] ? albd_pkg::TIME_MAX : st_sum[TW-1:0];
    end else begin
      stable_time_nxt = '0;
    end

    decode     = stable_time_nxt > stable_time_needed_r;
    released_c = decode && (s1_data_r.sample > release_level_r);
    set_c      = released_c ? albd_pkg::SET_NONE : s1_nearest_r;

    // Release clears the hold time before it accumulates
    hold_base = released_c ? '0 : held_time_r;
    hold_sum  = {1'b0, hold_base} + {1'b0, s1_data_r.elapsed};

    current_set_nxt = current_set_r;
    prior_set_nxt   = prior_set_r;
    held_time_nxt   = held_time_r;

    out_data_nxt             = '0;
    out_data_nxt.released    = released_c;

    if (decode) begin
      if (current_set_r != set_c) begin
        held_time_nxt   = '0;
        prior_set_nxt   = current_set_r;
        current_set_nxt = set_c;
        out_data_nxt.notify_menu = s1_data_r.menu_active;
        out_data_nxt.notify_host = !s1_data_r.menu_active;
      end else begin
        held_time_nxt = hold_sum[TW] ? albd_pkg::TIME_MAX : hold_sum[TW-1:0];
        out_data_nxt.start_menu = (held_time_nxt == reboot_hold_time_r) &&
                                  (current_set_r == albd_pkg::SET_ALL4) &&
                                  !s1_data_r.menu_active;
      end
    end

    out_data_nxt.buttons          = current_set_nxt;
    out_data_nxt.previous_buttons = prior_set_nxt;
    out_data_nxt.hold_time        = held_time_nxt;
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r    <= in_data;
      s1_nearest_r <= nearest_c;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Decoder state advances as each request leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      stable_time_r <= '0;
      current_set_r <= '0;
      prior_set_r   <= '0;
      held_time_r   <= '0;
    end else if (s1_move) begin
      last_sample_r <= last_sample_nxt;
      stable_time_r <= stable_time_nxt;
      current_set_r <= current_set_nxt;
      prior_set_r   <= prior_set_nxt;
      held_time_r   <= held_time_nxt;
    end
  end

  // Checks
  `ALBD_ASSERT_NOW(a_notify_excl, clk, rst_n, out_valid_r,
                   !(out_data_r.notify_host && out_data_r.notify_menu))
  `ALBD_ASSERT_NOW(a_start_menu_set, clk, rst_n, out_valid_r && out_data_r.start_menu,
                   out_data_r.buttons == albd_pkg::SET_ALL4 &&
                   out_data_r.hold_time == reboot_hold_time_r)
  `ALBD_ASSERT_NOW(a_released_none, clk, rst_n, out_valid_r && out_data_r.released,
                   out_data_r.buttons == albd_pkg::SET_NONE)
  `ALBD_ASSERT_NEXT(a_state_tracks_out, clk, rst_n, s1_move,
                    out_data_r.buttons == current_set_r &&
                    out_data_r.hold_time == held_time_r)

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // Ladder levels, entry 0 at the low end; entry 0 is the open line
  localparam logic [16*12-1:0] KEY_LEVELS = {
    12'h070, 12'h0FA, 12'h095, 12'h235, 12'h080, 12'h154, 12'h0B1, 12'h55D,
    12'h076, 12'h11E, 12'h0A0, 12'h308, 12'h086, 12'h196, 12'h0C0, 12'hFFF
  };

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  albd_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  albd_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [15:0]    cfg_data  = '0;

  // Register copies of the decoder, loaded with the reset values
  logic [11:0] delta_q   = 12'd10;
  logic [15:0] need_q    = 16'd200;
  logic [11:0] release_q = 12'h800;
  logic [15:0] reboot_q  = 16'd3000;

  // Decoder state copies
  logic [11:0] last_sample = '0;
  logic [15:0] stable_time = '0;
  logic [3:0]  cur_set     = '0;
  logic [3:0]  prior_set   = '0;
  logic [15:0] held_time   = '0;

  albd_pkg::out_t pending_decodes [$];

  bit             idle_on      = 1'b1;
  bit             hold_off_req = 1'b0;
  int unsigned    n_requests   = 0;
  int unsigned    n_results    = 0;
  int unsigned    n_changes    = 0;
  int unsigned    n_menu_start = 0;
  int unsigned    n_released   = 0;
  int unsigned    mismatches   = 0;
  int unsigned    quiet_cycles = 0;
  albd_pkg::out_t want;
  logic           bad;

  adc_ladder_button_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the decoder copy by one reading and return the expected result
  function automatic albd_pkg::out_t decode_reading(albd_pkg::in_t req);
    albd_pkg::out_t res;
    logic [3:0] nearest;
    int best;
    int err;
    res = '0;
    if (abs_diff(int'(req.sample), int'(last_sample)) < int'(delta_q))
      stable_time = sat_sum(stable_time, req.elapsed);
    else
      stable_time = '0;
    last_sample = req.sample;
    if (stable_time > need_q) begin
      nearest = albd_pkg::SET_NONE;
      if (req.sample > release_q) begin
        res.released = 1'b1;
        held_time = '0;
      end else begin
        best = 65535;
        for (int i = 1; i < 16; i++) begin
          err = abs_diff(int'(req.sample), int'(KEY_LEVELS[i*12 +: 12]));
          // strict compare: the lowest index keeps a tie
          if (err < best) begin
            best = err;
            nearest = i[3:0];
          end
        end
      end
      if (cur_set != nearest) begin
        held_time = '0;
        prior_set = cur_set;
        cur_set = nearest;
        if (req.menu_active) res.notify_menu = 1'b1;
        else res.notify_host = 1'b1;
      end else begin
        held_time = sat_sum(held_time, req.elapsed);
        if (held_time == reboot_q && cur_set == albd_pkg::SET_ALL4 && !req.menu_active)
          res.start_menu = 1'b1;
      end
    end
    res.buttons = cur_set;
    res.previous_buttons = prior_set;
    res.hold_time = held_time;
    return res;
  endfunction

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_item(logic [11:0] smp, logic [15:0] el, logic menu);
    albd_pkg::in_t req;
    int unsigned gap;
    req.sample = smp;
    req.elapsed = el;
    req.menu_active = menu;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_decodes.push_back(decode_reading(req));
    n_requests++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [11:0] delta, logic [15:0] need, logic [11:0] rel,
                              logic [15:0] reboot);
    albd_pkg::cfg_reg_t idx;
    logic [15:0] val;
    for (int r = 0; r < 4; r++) begin
      idx = albd_pkg::cfg_reg_t'(r);
      case (idx)
        albd_pkg::CFG_STABLE_DELTA:       val = {4'd0, delta};
        albd_pkg::CFG_STABLE_TIME_NEEDED: val = need;
        albd_pkg::CFG_RELEASE_LEVEL:      val = {4'd0, rel};
        default:                          val = reboot;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        albd_pkg::CFG_STABLE_DELTA:       delta_q = val[11:0];
        albd_pkg::CFG_STABLE_TIME_NEEDED: need_q = val;
        albd_pkg::CFG_RELEASE_LEVEL:      release_q = val[11:0];
        default:                          reboot_q = val;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Runs of steady readings around a target, mixed with noise
  task automatic send_stream(int unsigned count);
    int unsigned sent, run_len, span, k, pick, r;
    int target, smp;
    logic menu;
    logic [15:0] el;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_item(12'($urandom_range(4095)), 16'($urandom_range(65535)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        if (pick < 30 && release_q != 12'hFFF)
          target = $urandom_range(4095, int'(release_q) + 1);
        else if (pick < 50)
          target = int'(KEY_LEVELS[15*12 +: 12]);
        else if (pick < 85)
          target = int'(KEY_LEVELS[$urandom_range(15, 1)*12 +: 12]);
        else
          target = $urandom_range(4095);
        span = (delta_q > 12'd1) ? ((delta_q > 12'd9) ? 8 : int'(delta_q) - 1) : 0;
        run_len = $urandom_range(12, 2);
        menu = ($urandom_range(3) == 0);
        for (k = 0; k < run_len && sent < count; k++) begin
          smp = target + int'($urandom_range(span)) - int'(span / 2);
          if (smp < 0) smp = 0;
          if (smp > 4095) smp = 4095;
          if ($urandom_range(9) == 0) menu = ~menu;
          r = $urandom_range(99);
          // aim the four-button hold exactly at the reboot hold time
          if (cur_set == albd_pkg::SET_ALL4 && held_time < reboot_q && r < 35)
            el = reboot_q - held_time;
          else if (r < 60)
            el = 16'($urandom_range(int'(need_q) / 2 + 2));
          else if (r < 85)
            el = 16'($urandom_range(63));
          else if (r < 95)
            el = 16'($urandom_range(65535));
          else
            el = 16'hFFFF;
          send_item(smp[11:0], el, menu);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(logic [11:0] delta, logic [15:0] need, logic [11:0] rel,
                           logic [15:0] reboot, int unsigned count);
    settle();
    write_config(delta, need, rel, reboot);
    idle_on = 1'b0;
    send_stream(count / 4);
    idle_on = 1'b1;
    send_stream(count - count / 4);
  endtask

  // Reset registers: tie, release, saturation and menu start by hand
  task automatic test_directed_defaults();
    send_item(12'h070, 16'd0, 1'b0);
    send_item(12'h070, 16'hFFFF, 1'b0);
    send_item(12'h070, 16'd3000, 1'b0);
    send_item(12'h070, 16'hFFFF, 1'b1);
    send_item(12'h073, 16'd100, 1'b1);
    send_item(12'hFFF, 16'd1, 1'b0);
    send_item(12'hFFF, 16'hFFFF, 1'b0);
    send_item(12'hFFF, 16'd500, 1'b0);
    send_item(12'h000, 16'hFFFF, 1'b0);
    send_item(12'h000, 16'd201, 1'b0);
  endtask

  // Every reading counts as stable, so each ladder level decodes at once
  task automatic test_each_ladder_code();
    settle();
    write_config(12'hFFF, 16'd0, 12'hFFF, 16'd0);
    for (int i = 1; i < 15; i++)
      send_item(KEY_LEVELS[i*12 +: 12], 16'd1, i[0]);
    send_item(KEY_LEVELS[15*12 +: 12], 16'd0, 1'b0);
    send_item(KEY_LEVELS[15*12 +: 12], 16'd0, 1'b0);
  endtask

  task automatic test_config_extremes();
    run_phase(12'd0, 16'd0, 12'd0, 16'd0, 100);
    run_phase(12'hFFF, 16'hFFFF, 12'hFFF, 16'hFFFF, 100);
    run_phase(12'd40, 16'd0, 12'd0, 16'd5, 100);
  endtask

  task automatic test_random_decode();
    run_phase(12'd10, 16'd200, 12'h800, 16'd3000, 200);
    for (int p = 0; p < 5; p++)
      run_phase(12'($urandom_range(40, 1)), 16'($urandom_range(400)),
                12'($urandom_range(4095, 256)), 16'($urandom_range(300)), 200);
  endtask

  // Hold the result side off long enough for the block to stall its input
  task automatic test_backpressure();
    settle();
    write_config(12'd20, 16'd50, 12'h600, 16'd120);
    idle_on = 1'b0;
    hold_off_req = 1'b1;
    send_stream(60);
    idle_on = 1'b1;
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected", n_results);
      end else begin
        want = pending_decodes.pop_front();
        bad = (out_data.buttons !== want.buttons) ||
              (out_data.previous_buttons !== want.previous_buttons) ||
              (out_data.notify_host !== want.notify_host) ||
              (out_data.notify_menu !== want.notify_menu) ||
              (out_data.hold_time !== want.hold_time) ||
              (out_data.start_menu !== want.start_menu) ||
              (out_data.released !== want.released);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d (expected/actual): buttons %0d/%0d prev %0d/%0d",
                     n_results, want.buttons, out_data.buttons, want.previous_buttons,
                     out_data.previous_buttons);
            $display("  host %b/%b menu %b/%b", want.notify_host, out_data.notify_host,
                     want.notify_menu, out_data.notify_menu);
            $display("  hold %0d/%0d start_menu %b/%b released %b/%b",
                     want.hold_time, out_data.hold_time, want.start_menu, out_data.start_menu,
                     want.released, out_data.released);
          end
        end
        if (want.notify_host || want.notify_menu) n_changes++;
        if (want.start_menu) n_menu_start++;
        if (want.released) n_released++;
      end
    end
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("adc_ladder_button_decoder_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_each_ladder_code();
    test_config_extremes();
    test_random_decode();
    test_backpressure();
    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d readings through reset, per-level, extreme, random and stalled setups.",
             n_requests);
    $display("Checked %0d results: %0d set changes, %0d menu starts, %0d releases, %0d bad.",
             n_results, n_changes, n_menu_start, n_released, mismatches);
    if (mismatches == 0)
      $display("adc_ladder_button_decoder_core test passed");
    else
      $display("adc_ladder_button_decoder_core test failed");
    $finish;
  end

endmodule

// ===== adc_ladder_button_decoder_core.f =====
+incdir+rtl/core
rtl/core/albd_pkg.sv
rtl/core/albd_nearest.sv
rtl/core/adc_ladder_button_decoder_core.sv
test/tb.sv
